// ----- sv/mahp_pkg.sv -----
// shared types, constants and lookup tables for the mpeg audio header parser
// no dependencies; used by every module of the block but the checker
`default_nettype none
package mahp_pkg;

    localparam logic [7:0] SYNC_BYTE   = 8'hFF;
    localparam logic [7:0] SYNC_MASK1  = 8'hE0;
    localparam logic [7:0] MATCH_MASK3 = 8'hC3;
    localparam logic [3:0] BRI_BAD     = 4'hF;
    localparam logic [1:0] SR_BAD      = 2'd3;
    localparam logic [1:0] VER_CODE_BAD   = 2'd1;
    localparam logic [1:0] LAYER_CODE_BAD = 2'd0;
    localparam logic [1:0] MODE_MONO   = 2'd3;

    localparam logic [1:0] VER_MPEG1  = 2'd0;
    localparam logic [1:0] VER_MPEG2  = 2'd1;
    localparam logic [1:0] VER_MPEG25 = 2'd2;

    localparam logic [1:0] LAYER_1 = 2'd1;
    localparam logic [1:0] LAYER_2 = 2'd2;
    localparam logic [1:0] LAYER_3 = 2'd3;

    localparam logic [10:0] SPF_384  = 11'd384;
    localparam logic [10:0] SPF_576  = 11'd576;
    localparam logic [10:0] SPF_1152 = 11'd1152;

    localparam logic [5:0] SIDE_9  = 6'd9;
    localparam logic [5:0] SIDE_17 = 6'd17;
    localparam logic [5:0] SIDE_32 = 6'd32;

    localparam logic [15:0] RATE_RESET = 16'd44100;
    localparam logic [6:0]  KBPS_SCALE = 7'd125;
    localparam logic [10:0] LEN_MAX    = 11'd2047;
    localparam logic [8:0]  AVG_DEN_MAX = 9'd511;

    localparam int unsigned DIV_NUM_W = 26;
    localparam int unsigned DIV_DEN_W = 16;
    localparam int unsigned OUT_W     = 56;

    localparam logic [8:0] RATE_TAB [0:1][0:2][0:14] = '{
        '{
            '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
              9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448},
            '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
              9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384},
            '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
              9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320}
        },
        '{
            '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
              9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256},
            '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
              9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160},
            '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
              9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160}
        }
    };

    localparam logic [15:0] FREQ_TAB [0:8] = '{
        16'd44100, 16'd48000, 16'd32000, 16'd22050, 16'd24000,
        16'd16000, 16'd11025, 16'd12000, 16'd8000
    };

    // one classified header as it travels from front to back
    typedef struct packed {
        logic [31:0] word;
        logic        start;
        logic        ok;
        logic [1:0]  version;
        logic [1:0]  layer;
        logic [15:0] rate;
        logic [10:0] spf;
        logic [5:0]  side;
    } hdr_entry_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

    function automatic logic [8:0] kbps_lookup(input logic [1:0] version,
                                               input logic [1:0] layer,
                                               input logic [3:0] bri);
        logic       ti;
        logic [1:0] li;
        logic [3:0] bi;
        ti = (version != VER_MPEG1);
        li = (layer == LAYER_1) ? 2'd0 : (layer == LAYER_2) ? 2'd1 :
             (layer == LAYER_3) ? 2'd2 : 2'd0;
        bi = (bri == BRI_BAD) ? 4'd14 : bri;
        return RATE_TAB[ti][li][bi];
    endfunction

endpackage
`default_nettype wire

// ----- sv/mahp_fifo.sv -----
// two-entry queue of classified headers between front and back
// depends on mahp_pkg for the entry type
`default_nettype none
module mahp_fifo (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire mahp_pkg::hdr_entry_t push_data,
    input  wire logic                pop,
    output      mahp_pkg::hdr_entry_t pop_data,
    output      logic                full,
    output      logic                empty
);
    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    mahp_pkg::hdr_entry_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign full     = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ----- sv/mahp_front.sv -----
// front end: takes header beats, checks them against the open stream and
// latches stream properties; depends on mahp_pkg
`default_nettype none
module mahp_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    input  wire logic [31:0]         in_word,
    input  wire logic                in_start,
    input  wire logic                q_full,
    output      logic                in_ready,
    output      logic                q_push,
    output      mahp_pkg::hdr_entry_t q_data
);
    logic        open_reg;
    logic [31:0] ref_reg;
    logic [1:0]  ver_reg, layer_reg;
    logic [15:0] rate_reg;
    logic [10:0] spf_reg;
    logic [5:0]  side_reg;

    logic [7:0]  b0, b1, b2, b3;
    logic        start_ok, later_ok, take_start;
    logic [1:0]  ver_next, layer_next;
    logic [15:0] rate_next;
    logic [10:0] spf_next;
    logic [5:0]  side_next;
    logic [3:0]  freq_idx;
    logic        mono;

    assign b0 = in_word[31:24];
    assign b1 = in_word[23:16];
    assign b2 = in_word[15:8];
    assign b3 = in_word[7:0];

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    always_comb begin
        start_ok = (b0 == mahp_pkg::SYNC_BYTE)
                && ((b1 & mahp_pkg::SYNC_MASK1) == mahp_pkg::SYNC_MASK1)
                && (b1[4:3] != mahp_pkg::VER_CODE_BAD)
                && (b1[2:1] != mahp_pkg::LAYER_CODE_BAD)
                && (b2[7:4] != mahp_pkg::BRI_BAD)
                && (b2[3:2] != mahp_pkg::SR_BAD);
        later_ok = open_reg && (b0 == mahp_pkg::SYNC_BYTE)
                && (b1 == ref_reg[23:16])
                && (b2[3:2] == ref_reg[11:10])
                && ((b3 & mahp_pkg::MATCH_MASK3) == (ref_reg[7:0] & mahp_pkg::MATCH_MASK3))
                && (b2[7:4] != mahp_pkg::BRI_BAD);

        unique case (b1[4:3])
            2'd3:    ver_next = mahp_pkg::VER_MPEG1;
            2'd2:    ver_next = mahp_pkg::VER_MPEG2;
            default: ver_next = mahp_pkg::VER_MPEG25;
        endcase
        freq_idx = 4'(b2[3:2]) + ((ver_next == mahp_pkg::VER_MPEG1) ? 4'd0 :
                   (ver_next == mahp_pkg::VER_MPEG2) ? 4'd3 : 4'd6);
        // sample-rate code 3 is rejected, so the index stays below nine
        rate_next = (freq_idx > 4'd8) ? mahp_pkg::RATE_RESET : mahp_pkg::FREQ_TAB[freq_idx];

        unique case (b1[2:1])
            2'd3: begin
                layer_next = mahp_pkg::LAYER_1;
                spf_next   = mahp_pkg::SPF_384;
            end
            2'd2: begin
                layer_next = mahp_pkg::LAYER_2;
                spf_next   = mahp_pkg::SPF_1152;
            end
            default: begin
                layer_next = mahp_pkg::LAYER_3;
                spf_next   = (ver_next == mahp_pkg::VER_MPEG1) ? mahp_pkg::SPF_1152
                                                               : mahp_pkg::SPF_576;
            end
        endcase

        mono = (b3[7:6] == mahp_pkg::MODE_MONO);
        if (ver_next == mahp_pkg::VER_MPEG1) begin
            side_next = mono ? mahp_pkg::SIDE_17 : mahp_pkg::SIDE_32;
        end else begin
            side_next = mono ? mahp_pkg::SIDE_9 : mahp_pkg::SIDE_17;
        end

        take_start = in_start && start_ok;

        q_data.word  = in_word;
        q_data.start = in_start;
        q_data.ok    = in_start ? start_ok : later_ok;
        if (take_start) begin
            q_data.version = ver_next;
            q_data.layer   = layer_next;
            q_data.rate    = rate_next;
            q_data.spf     = spf_next;
            q_data.side    = side_next;
        end else begin
            q_data.version = ver_reg;
            q_data.layer   = layer_reg;
            q_data.rate    = rate_reg;
            q_data.spf     = spf_reg;
            q_data.side    = side_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg  <= 1'b0;
            ref_reg   <= '0;
            ver_reg   <= mahp_pkg::VER_MPEG1;
            layer_reg <= mahp_pkg::LAYER_1;
            rate_reg  <= mahp_pkg::RATE_RESET;
            spf_reg   <= mahp_pkg::SPF_1152;
            side_reg  <= mahp_pkg::SIDE_32;
        end else if (q_push && take_start) begin
            open_reg  <= 1'b1;
            ref_reg   <= in_word;
            ver_reg   <= ver_next;
            layer_reg <= layer_next;
            rate_reg  <= rate_next;
            spf_reg   <= spf_next;
            side_reg  <= side_next;
        end
    end
endmodule
`default_nettype wire

// ----- sv/mahp_div.sv -----
// radix-2 restoring divider, one quotient bit per cycle
// depends on mahp_pkg for widths and request/response structs
`default_nettype none
module mahp_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mahp_pkg::div_req_t req,
    output      mahp_pkg::div_rsp_t rsp
);
    localparam int unsigned NW = mahp_pkg::DIV_NUM_W;
    localparam int unsigned DW = mahp_pkg::DIV_DEN_W;
    localparam int unsigned CW = $clog2(NW + 1);

    logic          busy_reg, done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] num_reg;
    logic [DW:0]   rem_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   rem_sh, rem_sub;
    logic          q_bit;

    always_comb begin
        rem_sh  = {rem_reg[DW-1:0], num_reg[NW-1]};
        q_bit   = (rem_sh >= {1'b0, den_reg});
        rem_sub = q_bit ? (rem_sh - {1'b0, den_reg}) : rem_sh;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = num_reg;

    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[NW-2:0], q_bit};
            rem_reg <= rem_sub;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- sv/mahp_back.sv -----
// back end: bitrate lookup, frame and payload length, rate statistics and
// the output register; depends on mahp_pkg and mahp_div
`default_nettype none
module mahp_back #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_empty,
    input  wire mahp_pkg::hdr_entry_t          q_data,
    output      logic                          q_pop,
    output      logic                          out_valid,
    input  wire logic                          out_ready,
    output      logic [mahp_pkg::OUT_W-1:0]    out_data
);
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL1 = 6'b000010,
        ST_MUL2 = 6'b000100,
        ST_DIVF = 6'b001000,
        ST_DIVA = 6'b010000,
        ST_FIN  = 6'b100000
    } back_state_t;

    localparam int unsigned NW = mahp_pkg::DIV_NUM_W;
    localparam int unsigned DW = mahp_pkg::DIV_DEN_W;
    localparam int unsigned XW = COUNT_WIDTH + 9;

    back_state_t          state_reg, state_next;
    mahp_pkg::hdr_entry_t ent_reg;
    logic [8:0]           kb_reg;
    logic [NW-1:0]        prod_reg;
    logic [12:0]          lenq_reg;
    logic [8:0]           avq_reg;
    logic                 go_reg;
    logic                 rc_reg;
    logic [8:0]           avg_reg;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic                 out_valid_reg;
    logic [mahp_pkg::OUT_W-1:0] out_data_reg;

    mahp_pkg::div_req_t   dreq;
    mahp_pkg::div_rsp_t   drsp;

    logic [8:0]           diff;
    logic [XW-1:0]        cnt_ext;
    logic [DW-1:0]        avg_den;
    logic                 out_free;
    logic [13:0]          len_raw;
    logic [10:0]          fb, db, sub;
    logic                 avg_update;
    logic [8:0]           avg_new;
    logic                 rc_new;
    logic [COUNT_WIDTH-1:0] cnt_new;

    mahp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;

    always_comb begin
        diff    = (kb_reg >= avg_reg) ? (kb_reg - avg_reg) : (avg_reg - kb_reg);
        cnt_ext = XW'(cnt_reg);
        // a difference below 511 (table entries stop at 448) over any count of 511 or more is zero either way
        if (cnt_ext == '0) begin
            avg_den = DW'(1);
        end else if (cnt_ext >= XW'(mahp_pkg::AVG_DEN_MAX)) begin
            avg_den = DW'(mahp_pkg::AVG_DEN_MAX);
        end else begin
            avg_den = DW'(cnt_ext[8:0]);
        end

        dreq.start = go_reg;
        if (state_reg == ST_DIVA) begin
            dreq.num = NW'(diff);
            dreq.den = avg_den;
        end else begin
            dreq.num = prod_reg;
            dreq.den = ent_reg.rate;
        end
    end

    always_comb begin
        len_raw = 14'(lenq_reg);
        if (ent_reg.word[9]) begin
            len_raw = len_raw + ((ent_reg.layer == mahp_pkg::LAYER_1) ? 14'd4 : 14'd1);
        end
        fb  = (len_raw > 14'(mahp_pkg::LEN_MAX)) ? mahp_pkg::LEN_MAX : len_raw[10:0];
        sub = 11'd4 + ((ent_reg.layer == mahp_pkg::LAYER_3) ? 11'(ent_reg.side) : 11'd0);
        db  = (fb > sub) ? (fb - sub) : 11'd0;

        avg_update = !ent_reg.start && !rc_reg;
        if (ent_reg.start) begin
            avg_new = kb_reg;
            rc_new  = 1'b1;
            cnt_new = COUNT_WIDTH'(1);
        end else begin
            avg_new = avg_reg;
            rc_new  = rc_reg;
            if (avg_update) begin
                avg_new = (kb_reg >= avg_reg) ? (avg_reg + avq_reg) : (avg_reg - avq_reg);
            end else if (avg_reg != kb_reg) begin
                rc_new = 1'b0;
            end
            cnt_new = (cnt_reg == '1) ? cnt_reg : (cnt_reg + 1'b1);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (!q_empty) state_next = q_data.ok ? ST_MUL1 : ST_FIN;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_DIVF;
            ST_DIVF: if (drsp.done) state_next = avg_update ? ST_DIVA : ST_FIN;
            ST_DIVA: if (drsp.done) state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ent_reg <= q_data;
            kb_reg  <= mahp_pkg::kbps_lookup(q_data.version, q_data.layer,
                                             q_data.word[15:12]);
        end
        if (state_reg == ST_MUL1) begin
            prod_reg <= NW'(16'(kb_reg) * 16'(mahp_pkg::KBPS_SCALE));
        end
        if (state_reg == ST_MUL2) begin
            prod_reg <= NW'(prod_reg[15:0]) * NW'(ent_reg.spf);
        end
        if (state_reg == ST_DIVF && drsp.done) begin
            lenq_reg <= drsp.quot[12:0];
        end
        if (state_reg == ST_DIVA && drsp.done) begin
            avq_reg <= drsp.quot[8:0];
        end
        if (state_reg == ST_FIN && out_free) begin
            if (ent_reg.ok) begin
                out_data_reg <= {avg_new, rc_new, ent_reg.word[7:6], !ent_reg.word[16],
                                 ent_reg.word[9], ent_reg.side, db, fb, kb_reg,
                                 ent_reg.layer, ent_reg.version, 1'b1};
            end else begin
                out_data_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            go_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            rc_reg        <= 1'b1;
            avg_reg       <= '0;
            cnt_reg       <= '0;
        end else begin
            state_reg <= state_next;
            go_reg    <= (state_reg == ST_MUL2) ||
                         (state_reg == ST_DIVF && drsp.done && avg_update);
            if (state_reg == ST_FIN && out_free) begin
                out_valid_reg <= 1'b1;
                if (ent_reg.ok) begin
                    rc_reg  <= rc_new;
                    avg_reg <= avg_new;
                    cnt_reg <= cnt_new;
                end
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ----- sv/mpeg_audio_header_parser.sv -----
// channel   dir  tdata fields (lsb first)                               tuser
// s_        in   header_word[31:0]                                       start_stream
// m_        out  valid_res, mpeg_version, layer_number, kbps, frame_bytes,
//                data_bytes, side_info_bytes, padded, crc_present,
//                channel_mode, constant_rate, average_kbps (56 bits)     -
// an accepted header passes ST_MUL1, ST_MUL2 and ST_DIVF in the back end, one whose
// bitrate average moves also ST_DIVA; a rejected header goes straight to ST_FIN. the
// shared radix-2 divider (one quotient bit per cycle) sets the pace of both divisions.
// the front classifies one beat a cycle into a two-entry queue and stalls only
// when the queue is full; on m_ stall the back end runs on as far as ST_FIN.
// reset is synchronous and active low; no clearing pass is needed.
// top level: mahp_front, mahp_fifo, mahp_back; depends on mahp_pkg
`default_nettype none
module mpeg_audio_header_parser #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [31:0] s_tdata,   // header_word
    input  wire logic        s_tuser,   // start_stream
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [55:0] m_tdata    // valid_res .. average_kbps, see table above
);
    logic                 q_push, q_pop, q_full, q_empty;
    mahp_pkg::hdr_entry_t q_in, q_out;

    mahp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_word   (s_tdata),
        .in_start  (s_tuser),
        .q_full    (q_full),
        .in_ready  (s_tready),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    mahp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    mahp_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );
endmodule
`default_nettype wire

// ----- sv/mahp_checker.sv -----
// port-level checks on the header parser's result stream, bound to the top
// depends only on the top level's ports
`default_nettype none
module mahp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata
);
    // a stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // rejected headers carry only zeros
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[55:1] == 55'd0)
        else $error("rejected result has nonzero fields");

    a_layer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[4:3] != 2'd0)
        else $error("accepted result has layer zero");

    // payload never exceeds frame length
    a_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[35:25] <= m_tdata[24:14])
        else $error("payload longer than frame");
endmodule

bind mpeg_audio_header_parser mahp_checker u_mahp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
